[src/lru_pkg.sv]
package lru_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = 4;
  localparam int LINK_W = 5;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;

  localparam logic [LINK_W-1:0] NULL_IDX = LINK_W'(DEPTH);

  // request codes
  localparam logic [2:0] REQ_INS_FRONT = 3'd0;
  localparam logic [2:0] REQ_INS_BACK  = 3'd1;
  localparam logic [2:0] REQ_REM_FRONT = 3'd2;
  localparam logic [2:0] REQ_REM_BACK  = 3'd3;
  localparam logic [2:0] REQ_MOVE      = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [DATA_W-1:0] payload_in;
    logic [IDX_W-1:0]  entry_handle;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  handle_out;
    logic [DATA_W-1:0] payload_out;
    logic [CNT_W-1:0]  entry_count;
    logic              is_full;
    logic              is_empty;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture request
    logic step1;  // decide, read or write entry words
    logic step2;  // first link write
    logic step3;  // second link write, finish
  } cmd_t;

endpackage

[src/lru_if.sv]
interface lru_req_if;
  import lru_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lru_rsp_if;
  import lru_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[src/lru_ctrl.sv]
module lru_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lru_pkg::cmd_t cmd
);
  import lru_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_S1   = 3'd1;
  localparam logic [2:0] S_S2   = 3'd2;
  localparam logic [2:0] S_S3   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_S1;
        end
      end
      S_S1: begin
        cmd.step1 = 1'b1;
        state_next = S_S2;
      end
      S_S2: begin
        cmd.step2 = 1'b1;
        state_next = S_S3;
      end
      S_S3: begin
        cmd.step3 = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

[src/lru_dp.sv]
module lru_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  lru_pkg::cmd_t         cmd,
  input  lru_pkg::req_t         req_in,
  input  logic                  cfg_we,
  input  logic [4:0]            cfg_data,
  output lru_pkg::rsp_t         rsp
);
  import lru_pkg::*;

  // entry memories
  logic [DATA_W-1:0] payload_store [DEPTH];
  logic [LINK_W-1:0] next_link [DEPTH];
  logic [LINK_W-1:0] prev_link [DEPTH];
  logic [DEPTH-1:0]  entry_in_use;
  logic [IDX_W-1:0]  free_stack [DEPTH];
  logic [LINK_W-1:0] free_top;
  logic [LINK_W-1:0] head_index;
  logic [LINK_W-1:0] tail_index;
  logic [CNT_W-1:0]  count;
  logic [4:0]        max_capacity;

  req_t              req;
  logic [1:0]        status;
  logic [IDX_W-1:0]  ent;      // entry allocated, removed or moved
  logic [DATA_W-1:0] pout;
  logic [LINK_W-1:0] rd_prev;  // links of ent read in step one (old ends on insert)
  logic [LINK_W-1:0] rd_next;
  logic              act;      // request changes the list

  logic [CNT_W-1:0]  cap;
  logic              full_now;
  logic              is_ins, is_rem, is_mov;
  logic [IDX_W-1:0]  hidx, tidx, top_e;

  assign cap      = (max_capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : max_capacity;
  assign full_now = (count >= cap);
  assign is_ins   = (req.req_type == REQ_INS_FRONT) || (req.req_type == REQ_INS_BACK);
  assign is_rem   = (req.req_type == REQ_REM_FRONT) || (req.req_type == REQ_REM_BACK);
  assign is_mov   = (req.req_type == REQ_MOVE);
  assign hidx     = head_index[IDX_W-1:0];
  assign tidx     = tail_index[IDX_W-1:0];
  assign top_e    = free_stack[IDX_W'(free_top - 1'b1)];

  assign rsp.status      = status;
  assign rsp.handle_out  = (is_mov || !act) ? '0 : ent;
  assign rsp.payload_out = pout;
  assign rsp.entry_count = count;
  assign rsp.is_full     = full_now;
  assign rsp.is_empty    = (count == '0);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) max_capacity <= 5'd16;
    else if (cfg_we) max_capacity <= cfg_data;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_in_use <= '0;
      free_top     <= LINK_W'(DEPTH);
      head_index   <= NULL_IDX;
      tail_index   <= NULL_IDX;
      count        <= '0;
      for (int i = 0; i < DEPTH; i++) free_stack[i] <= IDX_W'(DEPTH - 1 - i);
    end else if (cmd.step1) begin
      if (is_ins && !(full_now || free_top == '0)) begin
        free_top <= free_top - 1'b1;
        entry_in_use[top_e] <= 1'b1;
        count <= count + 1'b1;
        if (tail_index == NULL_IDX) begin
          head_index <= {1'b0, top_e};
          tail_index <= {1'b0, top_e};
        end else if (req.req_type == REQ_INS_FRONT) begin
          head_index <= {1'b0, top_e};
        end else begin
          tail_index <= {1'b0, top_e};
        end
      end else if (is_rem && count != '0 && head_index < NULL_IDX
                   && tail_index < NULL_IDX) begin
        if (req.req_type == REQ_REM_FRONT) begin
          entry_in_use[hidx] <= 1'b0;
          free_stack[free_top[IDX_W-1:0]] <= hidx;
        end else begin
          entry_in_use[tidx] <= 1'b0;
          free_stack[free_top[IDX_W-1:0]] <= tidx;
        end
        free_top <= free_top + 1'b1;
        count <= count - 1'b1;
        if (head_index == tail_index) begin
          head_index <= NULL_IDX;
          tail_index <= NULL_IDX;
        end
      end
    end else if (cmd.step2 && act) begin
      // new end pointers after removal (from the links read in step one) or move
      if (is_rem && head_index != NULL_IDX) begin
        if (req.req_type == REQ_REM_FRONT) head_index <= rd_next;
        else tail_index <= rd_prev;
      end
      if (is_mov && ent != hidx) begin
        if (tidx == ent) tail_index <= rd_prev;
        head_index <= {1'b0, ent};
      end
    end
  end

  // request capture, decision and link updates
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= req_in;
    end
    if (cmd.step1) begin
      status <= ST_OK;
      pout   <= '0;
      act    <= 1'b0;
      ent    <= '0;
      if (is_ins) begin
        if (full_now || free_top == '0) status <= ST_FULL;
        else begin
          act <= 1'b1;
          ent <= top_e;
          rd_next <= head_index;
          rd_prev <= tail_index;
          payload_store[top_e] <= req.payload_in;
          next_link[top_e] <= (tail_index != NULL_IDX
                               && req.req_type == REQ_INS_FRONT) ? head_index : NULL_IDX;
          prev_link[top_e] <= (tail_index != NULL_IDX
                               && req.req_type == REQ_INS_BACK) ? tail_index : NULL_IDX;
        end
      end else if (is_rem) begin
        if (count == '0 || head_index >= NULL_IDX || tail_index >= NULL_IDX)
          status <= ST_EMPTY;
        else begin
          act <= 1'b1;
          if (req.req_type == REQ_REM_FRONT) begin
            ent <= hidx;
            pout <= payload_store[hidx];
            rd_next <= next_link[hidx];
            rd_prev <= prev_link[hidx];
          end else begin
            ent <= tidx;
            pout <= payload_store[tidx];
            rd_next <= next_link[tidx];
            rd_prev <= prev_link[tidx];
          end
        end
      end else if (is_mov) begin
        if (!entry_in_use[req.entry_handle]) status <= ST_UNUSED;
        else begin
          act <= 1'b1;
          ent <= req.entry_handle;
          rd_next <= next_link[req.entry_handle];
          rd_prev <= prev_link[req.entry_handle];
        end
      end
    end
    // step two: link old end to new entry, clear new end's link, move entry to head
    if (cmd.step2 && act) begin
      if (is_ins && rd_prev != NULL_IDX) begin
        if (req.req_type == REQ_INS_FRONT) prev_link[rd_next[IDX_W-1:0]] <= {1'b0, ent};
        else next_link[rd_prev[IDX_W-1:0]] <= {1'b0, ent};
      end
      if (is_rem && head_index != NULL_IDX) begin
        if (req.req_type == REQ_REM_FRONT) prev_link[rd_next[IDX_W-1:0]] <= NULL_IDX;
        else next_link[rd_prev[IDX_W-1:0]] <= NULL_IDX;
      end
      if (is_mov && ent != hidx) begin
        next_link[rd_prev[IDX_W-1:0]] <= (tidx == ent) ? NULL_IDX : rd_next;
        prev_link[ent] <= NULL_IDX;
        next_link[ent] <= head_index;
        prev_link[hidx] <= {1'b0, ent};
      end
    end
    // step three: finish move, successor points back past the moved entry
    if (cmd.step3 && act && is_mov && rd_prev != NULL_IDX
        && rd_next != NULL_IDX && head_index == {1'b0, ent}
        && rd_next != {1'b0, ent}) begin
      prev_link[rd_next[IDX_W-1:0]] <= rd_prev;
    end
  end

endmodule

[src/lru_recency_list_unit.sv]
// LRU recency list of 16 entries with a 32-bit payload each. A request is
// taken only while the unit is idle and its result appears after the steps
// capture, decide and read, link update and finish, held until it is
// taken; the next request is accepted in the cycle after that. The link
// stores take at most two writes each per step, which sets the sequence
// length. Entries hold no reset value; handles are handed out from a free
// stack with entry zero first. max_capacity may be written only while no
// request is in flight.
module lru_recency_list_unit (
  input  logic       clk,
  input  logic       rst,
  lru_req_if.sink    req,
  lru_rsp_if.source  rsp,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data
);
  import lru_pkg::*;

  cmd_t cmd;

  lru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  lru_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req_in   (req.payload),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .rsp      (rsp.payload)
  );

endmodule
